// ----- hw/rtl/byte_sliced_table_xor_transform_macros.svh -----
// Assertion macros for the byte-sliced table XOR transform.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef BYTE_SLICED_TABLE_XOR_TRANSFORM_MACROS_SVH
`define BYTE_SLICED_TABLE_XOR_TRANSFORM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSTX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSTX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bstx_pkg.sv -----
// Shared types and constants of the byte-sliced table XOR transform.
// No dependencies; used by the interfaces and every module.
package bstx_pkg;

  localparam int MaxBytes  = 32;
  localparam int MaxWords  = 8;
  localparam int WordW     = 32;
  localparam int ByteW     = 8;
  localparam int PosW      = $clog2(MaxBytes);
  localparam int WordIdxW  = $clog2(MaxWords);
  localparam int RowAddrW  = ByteW;
  localparam int RowDepth  = 1 << ByteW;
  localparam int GroupSize = 8;
  localparam int NumGroups = MaxBytes / GroupSize;
  localparam int WordsCfgW = 4;
  localparam int BytesCfgW = 6;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 6;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WORDS_IN_USE = 2'd0,
    REG_BYTES_IN_USE = 2'd1
  } reg_idx_e;

  typedef logic [MaxWords-1:0][WordW-1:0] row_t;

  typedef struct packed {
    cmd_e              command;
    logic [12:0]       table_row;
    logic [2:0]        table_word_index;
    logic [WordW-1:0]  table_word;
    logic [WordW-1:0]  element_word_0;
    logic [WordW-1:0]  element_word_1;
    logic [WordW-1:0]  element_word_2;
    logic [WordW-1:0]  element_word_3;
    logic [WordW-1:0]  element_word_4;
    logic [WordW-1:0]  element_word_5;
    logic [WordW-1:0]  element_word_6;
    logic [WordW-1:0]  element_word_7;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0]  result_word_0;
    logic [WordW-1:0]  result_word_1;
    logic [WordW-1:0]  result_word_2;
    logic [WordW-1:0]  result_word_3;
    logic [WordW-1:0]  result_word_4;
    logic [WordW-1:0]  result_word_5;
    logic [WordW-1:0]  result_word_6;
    logic [WordW-1:0]  result_word_7;
    logic              size_error;
  } out_item_t;

  // Control that travels with a transform into the XOR reduction.
  typedef struct packed {
    logic                valid;
    logic [MaxBytes-1:0] byte_mask;
    logic [MaxWords-1:0] word_mask;
    logic                size_err;
  } reduce_ctl_t;

endpackage

// ----- hw/rtl/bstx_if.sv -----
// Valid/ready channel interfaces for command and result words.
// Depends on bstx_pkg for the payload structs.
interface bstx_in_if import bstx_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bstx_out_if import bstx_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bstx_bank.sv -----
// One byte-position bank of the row table: 256 rows of 8 words.
// Depends on bstx_pkg; word-granular write, whole-row registered read.
module bstx_bank import bstx_pkg::*; (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [WordIdxW-1:0] wr_word_i,
  input  logic [RowAddrW-1:0] wr_addr_i,
  input  logic [WordW-1:0]    wr_data_i,
  input  logic                re_i,
  input  logic [RowAddrW-1:0] rd_addr_i,
  output row_t                rd_row_o
);

  // One memory per word lane so a write touches a single word of the row
  for (genvar w = 0; w < MaxWords; w++) begin : g_lane
    logic [WordW-1:0] mem [RowDepth];
    logic [WordW-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (we_i && (wr_word_i == WordIdxW'(w))) begin
        mem[wr_addr_i] <= wr_data_i;
      end
      if (re_i) begin
        rd_q <= mem[rd_addr_i];
      end
    end

    assign rd_row_o[w] = rd_q;
  end

endmodule

// ----- hw/rtl/bstx_reduce.sv -----
// Two-stage XOR reduction of the 32 selected rows into one result row.
// Depends on bstx_pkg; stage one folds groups of eight, stage two the rest.
module bstx_reduce import bstx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  reduce_ctl_t ctl_i,
  input  row_t        rows_i [MaxBytes],
  output logic        valid_o,
  output row_t        words_o,
  output logic        err_o
);

  row_t        part_d [NumGroups];
  row_t        part_q [NumGroups];
  reduce_ctl_t ctl_q;
  row_t        res_d;
  row_t        res_q;
  logic        valid_q;
  logic        err_q;

  // Fold each group of eight rows, dropping bytes not in use
  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      part_d[g] = '0;
      for (int k = 0; k < GroupSize; k++) begin
        if (ctl_i.byte_mask[g*GroupSize + k]) begin
          part_d[g] = part_d[g] ^ rows_i[g*GroupSize + k];
        end
      end
    end
  end

  // Fold the group partials and clear unused words
  always_comb begin
    res_d = '0;
    for (int g = 0; g < NumGroups; g++) begin
      res_d = res_d ^ part_q[g];
    end
    for (int w = 0; w < MaxWords; w++) begin
      if (!ctl_q.word_mask[w] || ctl_q.size_err) begin
        res_d[w] = '0;
      end
    end
  end

  // Advance control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q   <= '0;
      valid_q <= 1'b0;
    end else if (adv_i) begin
      ctl_q   <= ctl_i;
      valid_q <= ctl_q.valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      part_q <= part_d;
      res_q  <= res_d;
      err_q  <= ctl_q.size_err;
    end
  end

  assign valid_o = valid_q;
  assign words_o = res_q;
  assign err_o   = err_q;

endmodule

// ----- hw/rtl/byte_sliced_table_xor_transform.sv -----
// Top level of the byte-sliced table XOR transform.
// Depends on bstx_pkg, bstx_if, bstx_bank, bstx_reduce and the macros header.
//
// Usage:
//   in_i carries one command word per handshake. A write word loads one
//   32-bit word of one table row (byte position in table_row[12:8], byte
//   value in table_row[7:0]) and produces no result. A transform word looks
//   up each of the first bytes_in_use element bytes in its position's bank
//   and returns the XOR of the selected rows on out_o.
//   The config port (cfg_we_i, cfg_idx_i, cfg_data_i) sets words_in_use
//   (index 0) and bytes_in_use (index 1); write it only while idle.
//   A transform passes the input, bank read, group partial and result
//   registers to out_o. Throughput: one word per cycle unless out_o
//   stalls, writes and transforms mixed; all 32 banks are read in parallel.
//   A write is visible to any transform accepted after it.
//   Reset empties the pipeline and sets words_in_use to 1 and bytes_in_use
//   to 4; table contents are undefined until written.
//   A stall on out_o freezes every stage and drops in_i.ready in the same
//   cycle; nothing is lost or repeated.
`include "byte_sliced_table_xor_transform_macros.svh"

module byte_sliced_table_xor_transform import bstx_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  bstx_in_if.sink             in_i,
  bstx_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic                 adv;
  logic [WordsCfgW-1:0] words_q;
  logic [BytesCfgW-1:0] bytes_q;
  logic                 s1_valid_q;
  in_item_t             s1_item_q;
  logic [WordW-1:0]     s1_elem [MaxWords];
  logic [ByteW-1:0]     s1_byte [MaxBytes];
  logic [MaxBytes-1:0]  bank_we;
  row_t                 rows [MaxBytes];
  reduce_ctl_t          ctl_d;
  reduce_ctl_t          s2_ctl_q;
  logic                 size_err;
  logic                 res_valid;
  row_t                 res_words;
  logic                 res_err;

  // Whole pipeline moves unless the result register is held
  assign adv       = !res_valid || out_o.ready;
  assign in_i.ready = adv;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= WordsCfgW'(1);
      bytes_q <= BytesCfgW'(4);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WORDS_IN_USE: words_q <= cfg_data_i[WordsCfgW-1:0];
        REG_BYTES_IN_USE: bytes_q <= cfg_data_i[BytesCfgW-1:0];
        default: ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_i.valid) begin
      s1_item_q <= in_i.data;
    end
  end

  assign s1_elem[0] = s1_item_q.element_word_0;
  assign s1_elem[1] = s1_item_q.element_word_1;
  assign s1_elem[2] = s1_item_q.element_word_2;
  assign s1_elem[3] = s1_item_q.element_word_3;
  assign s1_elem[4] = s1_item_q.element_word_4;
  assign s1_elem[5] = s1_item_q.element_word_5;
  assign s1_elem[6] = s1_item_q.element_word_6;
  assign s1_elem[7] = s1_item_q.element_word_7;

  // Table banks, one per byte position
  for (genvar p = 0; p < MaxBytes; p++) begin : g_bank
    assign s1_byte[p] = s1_elem[p / 4][ByteW*(p % 4) +: ByteW];
    assign bank_we[p] = adv && s1_valid_q && (s1_item_q.command == CMD_WRITE)
                        && (s1_item_q.table_row[12:8] == PosW'(p));

    bstx_bank u_bank (
      .clk_i     (clk_i),
      .we_i      (bank_we[p]),
      .wr_word_i (s1_item_q.table_word_index),
      .wr_addr_i (s1_item_q.table_row[RowAddrW-1:0]),
      .wr_data_i (s1_item_q.table_word),
      .re_i      (adv),
      .rd_addr_i (s1_byte[p]),
      .rd_row_o  (rows[p])
    );
  end

  // Check the size setting
  assign size_err = (words_q == '0) || (words_q > WordsCfgW'(MaxWords))
                 || (bytes_q == '0) || (bytes_q > BytesCfgW'(MaxBytes))
                 || (5'((7'(bytes_q) + 7'd3) >> 2) != {1'b0, words_q});

  // Build the lookup control that travels with the read data
  always_comb begin
    ctl_d.valid    = s1_valid_q && (s1_item_q.command == CMD_XFORM);
    ctl_d.size_err = size_err;
    for (int b = 0; b < MaxBytes; b++) begin
      ctl_d.byte_mask[b] = BytesCfgW'(b) < bytes_q;
    end
    for (int w = 0; w < MaxWords; w++) begin
      ctl_d.word_mask[w] = WordsCfgW'(w) < words_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else if (adv) begin
      s2_ctl_q <= ctl_d;
    end
  end

  // XOR reduction and result register
  bstx_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .ctl_i   (s2_ctl_q),
    .rows_i  (rows),
    .valid_o (res_valid),
    .words_o (res_words),
    .err_o   (res_err)
  );

  assign out_o.valid              = res_valid;
  assign out_o.data.result_word_0 = res_words[0];
  assign out_o.data.result_word_1 = res_words[1];
  assign out_o.data.result_word_2 = res_words[2];
  assign out_o.data.result_word_3 = res_words[3];
  assign out_o.data.result_word_4 = res_words[4];
  assign out_o.data.result_word_5 = res_words[5];
  assign out_o.data.result_word_6 = res_words[6];
  assign out_o.data.result_word_7 = res_words[7];
  assign out_o.data.size_error    = res_err;

  // Checks
  `BSTX_ASSERT_NOW(a_stall_blocks_input, out_o.valid && !out_o.ready, !in_i.ready, "input taken during output stall")
  `BSTX_ASSERT_NOW(a_error_zeroes_result, out_o.valid && out_o.data.size_error, res_words == '0, "size error with nonzero result")
  `BSTX_ASSERT_NOW(a_unused_word_zero, out_o.valid && (words_q < WordsCfgW'(MaxWords)), out_o.data.result_word_7 == '0, "unused result word nonzero")
  `BSTX_ASSERT_NEXT(a_write_no_result, adv && s1_valid_q && (s1_item_q.command == CMD_WRITE), !s2_ctl_q.valid, "table write produced a result")

endmodule
